FILE: hw/rtl/srr_pkg.sv
// Shared constants, types and helpers for the selective-repeat receiver.
`default_nettype none
package srr_pkg;

  localparam int unsigned SEQ_BITS   = 4;
  localparam int unsigned MAX_WINDOW = 8;
  localparam int unsigned SEQ_SPACE  = 1 << SEQ_BITS;
  localparam int unsigned HALF_SPACE = SEQ_SPACE / 2;
  localparam int unsigned WIN_CAP    = (MAX_WINDOW < HALF_SPACE) ? MAX_WINDOW : HALF_SPACE;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WIN_W   = 4;
  localparam int unsigned NW      = SEQ_BITS + 1;
  localparam int unsigned CW      = (NW > WIN_W) ? NW : WIN_W;
  localparam int unsigned STEP_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned TDATA_W = ((SEQ_BITS + WORD_W + 7) / 8) * 8;
  localparam int unsigned PAD_W   = TDATA_W - SEQ_BITS - WORD_W;

  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

  // register index is paddr[2]
  localparam logic REG_WINDOW = 1'b0;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [WORD_W-1:0]   word_t;

  typedef enum logic [1:0] {
    KIND_DISCARD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  // window_size 0 acts as 1, large values saturate
  function automatic logic [NW-1:0] eff_window(input logic [WIN_W-1:0] win);
    logic [CW-1:0] w;
    logic [CW-1:0] n;
    w = CW'(win);
    if (w == '0) begin
      n = CW'(1);
    end else if (w > CW'(WIN_CAP)) begin
      n = CW'(WIN_CAP);
    end else begin
      n = w;
    end
    return NW'(n);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/selective_repeat_receiver.sv
// Top level: selective-repeat ARQ receiver with buffered in-order delivery.
// One packet per visit to idle; a result beat is registered, so the first
// result appears in the cycle after acceptance. A packet that delivers k words
// steps through one RAM read plus one output load per word, at most MAX_WINDOW
// words. Reset clears base and the received flags at once (flops); the payload
// RAM is not cleared and a slot is only read after it is written.
`default_nettype none
module selective_repeat_receiver (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tdata: seq_num, payload (then zero pad); tuser: checksum_ok
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [srr_pkg::TDATA_W-1:0]   s_axis_tdata,
  input  wire logic [0:0]                    s_axis_tuser,
  // tdata: ack_seq, data (then zero pad); tuser: result_kind
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic      [srr_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic      [1:0]                    m_axis_tuser,
  output logic                               m_axis_tlast,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srr_pkg::APB_AW-1:0]    paddr,
  input  wire logic [srr_pkg::APB_DW-1:0]    pwdata,
  output logic      [srr_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);
  import srr_pkg::*;

  logic [WIN_W-1:0] window;

  srr_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .window_o (window)
  );

  state_e              state_q, state_d;
  seq_t                base_q, base_d;
  logic [SEQ_SPACE-1:0] got_q, got_d;
  logic [STEP_W-1:0]   steps_q, steps_d;

  logic  out_valid_q, out_valid_d;
  kind_e out_kind_q, out_kind_d;
  seq_t  out_seq_q, out_seq_d;
  word_t out_data_q, out_data_d;
  logic  out_last_q, out_last_d;

  seq_t  in_seq;
  logic  in_ok;
  word_t in_word;
  logic  out_free;
  logic  in_acc;

  logic [NW-1:0] n_win;
  logic [NW-1:0] seq_off;
  logic [NW-1:0] back_lo;
  seq_t          base_nx;

  logic  ram_we;
  logic  ram_re;
  word_t ram_rdata;

  assign in_seq  = s_axis_tdata[SEQ_BITS-1:0];
  assign in_word = s_axis_tdata[SEQ_BITS +: WORD_W];
  assign in_ok   = s_axis_tuser[0];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign n_win   = eff_window(window);
  assign seq_off = NW'(seq_t'(in_seq - base_q));
  assign back_lo = NW'(SEQ_SPACE) - n_win;
  assign base_nx = base_q + seq_t'(1);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    got_d       = got_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_seq_d   = out_seq_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_d = 1'b1;
          out_seq_d   = in_seq;
          out_data_d  = '0;
          out_last_d  = 1'b1;
          steps_d     = '0;
          if (!in_ok) begin
            out_kind_d = KIND_DISCARD;
          end else if (seq_off >= n_win) begin
            // outside the window: re-ack if within one window behind base, otherwise drop
            out_kind_d = (seq_off >= back_lo) ? KIND_ACK : KIND_DISCARD;
          end else begin
            out_kind_d = KIND_ACK;
            if (!got_q[in_seq]) begin
              ram_we = 1'b1;
            end
            got_d[in_seq] = 1'b1;
            if ((in_seq == base_q) || got_q[base_q]) begin
              out_last_d = 1'b0;
              state_d    = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_kind_d    = KIND_DELIVER;
          out_seq_d     = base_q;
          out_data_d    = ram_rdata;
          got_d[base_q] = 1'b0;
          base_d        = base_nx;
          steps_d       = steps_q + STEP_W'(1);
          if ((steps_q == STEP_W'(MAX_WINDOW - 1)) || !got_q[base_nx]) begin
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            out_last_d = 1'b0;
            state_d    = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  srr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SEQ_SPACE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_seq),
    .wdata_i (in_word),
    .re_i    (ram_re),
    .raddr_i (base_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      got_q       <= '0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      got_q       <= got_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_seq_q  <= out_seq_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_data_q, out_seq_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_deliver_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> got_q[base_q])
    else $error("delivering a slot that is not held");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (steps_q < STEP_W'(MAX_WINDOW)))
    else $error("delivery run exceeds bound");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted packet gave no result beat");

  a_idle_base_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready && out_last_q && state_q == ST_IDLE)
      |-> !got_q[base_q])
    else $error("held packet at base left undelivered");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/srr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/srr_cfg.sv
// APB register block holding the receive window size.
`default_nettype none
module srr_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [srr_pkg::APB_AW-1:0]    paddr,
  input  wire logic [srr_pkg::APB_DW-1:0]    pwdata,
  output logic      [srr_pkg::APB_DW-1:0]    prdata,
  output logic                               pready,
  output logic      [srr_pkg::WIN_W-1:0]     window_o
);
  import srr_pkg::*;

  logic [WIN_W-1:0] win_q, win_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW);

  always_comb begin
    win_d = win_q;
    if (wr_en) begin
      win_d = pwdata[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else begin
      win_q <= win_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WINDOW) begin
      prdata = APB_DW'(win_q);
    end
  end

  assign window_o = win_q;

endmodule
`default_nettype wire
